>>> rtl/decimal_string_to_number_parser_defines.svh
// Assertion macros shared by the decimal string parser RTL.
// Each macro samples on clock and is disabled while reset is high.
`ifndef DECIMAL_STRING_TO_NUMBER_PARSER_DEFINES_SVH
`define DECIMAL_STRING_TO_NUMBER_PARSER_DEFINES_SVH

// Same-cycle implication between two conditions.
`define DSNP_ASSERT_NOW(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Condition in one cycle implies a property in the next cycle.
`define DSNP_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

>>> rtl/dsnp_pkg.sv
// Types, codes and constants for the decimal string parser.
// Used by every module of the block; no dependencies.
package dsnp_pkg;

   // Request and result payloads
   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_payload_type;

   typedef struct packed {
      logic        is_valid;
      logic        is_negative;
      logic [63:0] mantissa;
      logic [5:0]  fraction_digits;
      logic        saturated;
   } rsp_payload_type;

   // Character classes sent from front to back
   typedef logic [2:0] char_class_type;
   localparam char_class_type CLS_PLUS  = 3'd0;
   localparam char_class_type CLS_MINUS = 3'd1;
   localparam char_class_type CLS_DOT   = 3'd2;
   localparam char_class_type CLS_DIGIT = 3'd3;
   localparam char_class_type CLS_BAD   = 3'd4;

   // One classified character in the queue
   typedef struct packed {
      char_class_type cls;
      logic [3:0]     digit;
      logic           last;
      logic           len_ok;
   } item_type;

   // Front to queue write port
   typedef struct packed {
      logic     push;
      item_type item;
   } queue_write_type;

   // ASCII codes
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Limits and reset values
   localparam logic [5:0] MAX_LENGTH_RESET = 6'd20;
   localparam logic [6:0] POS_MAX          = 7'd127;
   localparam logic [5:0] FRAC_MAX         = 6'd63;
   localparam int         QUEUE_DEPTH_DEFAULT = 2;

endpackage

>>> rtl/decimal_string_to_number_parser.sv
// Decimal string parser: takes one ASCII character per cycle while req_stall is
// low and gives one result per string, on its final character. Sustained rate is
// one character per cycle when nothing stalls; the bound is the back end's 64-bit
// multiply-by-ten-and-add, done as one shift-add with a carry-out check in a
// single stage. A result is valid once its final character has been accepted into
// the queue between front and back and has then loaded the result register; a
// stalled earlier result can hold the character in the queue between the two.
// The front keeps taking characters while a result waits, until the queue
// (QUEUE_DEPTH entries) fills.
// The max_length register resets to 20 and should be written only while idle.

module decimal_string_to_number_parser #(
   parameter int QUEUE_DEPTH = dsnp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  dsnp_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output dsnp_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [5:0]                csr_data
);

   dsnp_pkg::queue_write_type queue_wr;
   dsnp_pkg::item_type        head;
   logic                      queue_full;
   logic                      head_valid;
   logic                      pop;

   dsnp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .queue_full  (queue_full),
      .queue_wr    (queue_wr)
   );

   dsnp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .queue_wr   (queue_wr),
      .full       (queue_full),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   dsnp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> rtl/dsnp_front.sv
// Front end: accepts characters, tracks string position and classifies each one.
// Holds the max_length register. Depends on dsnp_pkg.
`include "decimal_string_to_number_parser_defines.svh"

module dsnp_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  dsnp_pkg::req_payload_type req_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [5:0]                csr_data,
   input  logic                      queue_full,
   output dsnp_pkg::queue_write_type queue_wr
);

   logic [6:0] pos_ff, pos_in;
   logic [5:0] max_length_ff, max_length_in;
   logic [6:0] pos_inc;
   logic       accept;
   logic       is_first;
   logic       is_digit;
   dsnp_pkg::item_type item;

   assign csr_ready = 1'b1;
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // Saturating position count including the current character
   assign pos_inc  = (pos_ff == dsnp_pkg::POS_MAX) ? pos_ff : pos_ff + 7'd1;
   assign is_first = (pos_ff == 7'd0);
   assign is_digit = (req_payload.char_code >= dsnp_pkg::CHAR_ZERO) &&
                     (req_payload.char_code <= dsnp_pkg::CHAR_NINE);

   // Classify the character
   always_comb begin
      item.digit  = req_payload.char_code[3:0];
      item.last   = req_payload.last_char;
      item.len_ok = (pos_inc <= {1'b0, max_length_ff});
      if (is_first && req_payload.char_code == dsnp_pkg::CHAR_PLUS) begin
         item.cls = dsnp_pkg::CLS_PLUS;
      end else if (is_first && req_payload.char_code == dsnp_pkg::CHAR_MINUS) begin
         item.cls = dsnp_pkg::CLS_MINUS;
      end else if (req_payload.char_code == dsnp_pkg::CHAR_DOT) begin
         item.cls = dsnp_pkg::CLS_DOT;
      end else if (is_digit) begin
         item.cls = dsnp_pkg::CLS_DIGIT;
      end else begin
         item.cls = dsnp_pkg::CLS_BAD;
      end
   end

   assign queue_wr.push = accept;
   assign queue_wr.item = item;

   // Advance position, restart after the final character
   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         pos_in = req_payload.last_char ? 7'd0 : pos_inc;
      end
   end

   // Take configuration writes
   assign max_length_in = (csr_valid && csr_ready) ? csr_data : max_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= 7'd0;
         max_length_ff <= dsnp_pkg::MAX_LENGTH_RESET;
      end else begin
         pos_ff        <= pos_in;
         max_length_ff <= max_length_in;
      end
   end

   `DSNP_ASSERT_NEXT(a_pos_restart, accept && req_payload.last_char, pos_ff == 7'd0,
      "position not cleared after final character")
   `DSNP_ASSERT_NOW(a_sign_first_only, accept && !is_first,
      item.cls != dsnp_pkg::CLS_PLUS && item.cls != dsnp_pkg::CLS_MINUS,
      "sign classified past the first character")

endmodule

>>> rtl/dsnp_queue.sv
// Short queue of classified characters between front and back.
// Depends on dsnp_pkg.
`include "decimal_string_to_number_parser_defines.svh"

module dsnp_queue #(
   parameter int DEPTH = dsnp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dsnp_pkg::queue_write_type queue_wr,
   output logic                      full,
   output logic                      head_valid,
   output dsnp_pkg::item_type        head,
   input  logic                      pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   dsnp_pkg::item_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign do_push    = queue_wr.push && !full;
   assign do_pop     = pop && head_valid;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= queue_wr.item;
      end
   end

   `DSNP_ASSERT_NOW(a_no_push_when_full, full, !queue_wr.push,
      "push while queue full")
   `DSNP_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_FULL,
      "queue count beyond depth")

endmodule

>>> rtl/dsnp_back.sv
// Back end: accumulates the mantissa and flags, and registers the result.
// Depends on dsnp_pkg.
`include "decimal_string_to_number_parser_defines.svh"

module dsnp_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      head_valid,
   input  dsnp_pkg::item_type        head,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output dsnp_pkg::rsp_payload_type rsp_payload
);

   logic        seen_dot_ff, seen_dot_in;
   logic        seen_bad_ff, seen_bad_in;
   logic        minus_ff, minus_in;
   logic [63:0] value_ff, value_in;
   logic [5:0]  frac_ff, frac_in;
   logic        ovf_ff, ovf_in;
   logic        rsp_valid_ff, rsp_valid_in;
   dsnp_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic [67:0] times_ten;
   logic        push_ovf;
   logic        load;
   logic        str_valid;

   // Hold a final character while the result register is occupied and stalled
   assign pop  = head_valid && !(head.last && rsp_valid_ff && rsp_stall);
   assign load = pop && head.last;

   // Multiply by ten and add the digit
   assign times_ten = {1'b0, value_ff, 3'b000} + {3'b000, value_ff, 1'b0}
                    + {64'd0, head.digit};
   assign push_ovf  = |times_ten[67:64];

   // Update string state
   always_comb begin
      seen_dot_in = seen_dot_ff;
      seen_bad_in = seen_bad_ff;
      minus_in    = minus_ff;
      value_in    = value_ff;
      frac_in     = frac_ff;
      ovf_in      = ovf_ff;
      if (!seen_bad_ff) begin
         unique case (head.cls)
            dsnp_pkg::CLS_PLUS: begin
               minus_in = 1'b0;
            end
            dsnp_pkg::CLS_MINUS: begin
               minus_in = 1'b1;
            end
            dsnp_pkg::CLS_DOT: begin
               if (seen_dot_ff || head.last) begin
                  seen_bad_in = 1'b1;
               end
               seen_dot_in = 1'b1;
            end
            dsnp_pkg::CLS_DIGIT: begin
               if (push_ovf) begin
                  value_in = '1;
                  ovf_in   = 1'b1;
               end else begin
                  value_in = times_ten[63:0];
               end
               if (seen_dot_ff && frac_ff < dsnp_pkg::FRAC_MAX) begin
                  frac_in = frac_ff + 6'd1;
               end
            end
            default: begin
               seen_bad_in = 1'b1;
            end
         endcase
      end
   end

   // Build the result from the updated state
   assign str_valid = !seen_bad_in && head.len_ok;

   always_comb begin
      rsp_in.is_valid        = str_valid;
      rsp_in.is_negative     = str_valid && minus_in;
      rsp_in.mantissa        = str_valid ? value_in : 64'd0;
      rsp_in.fraction_digits = str_valid ? frac_in : 6'd0;
      rsp_in.saturated       = str_valid && ovf_in;
   end

   // Load on a final character, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_dot_ff  <= 1'b0;
         seen_bad_ff  <= 1'b0;
         minus_ff     <= 1'b0;
         value_ff     <= 64'd0;
         frac_ff      <= 6'd0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            seen_dot_ff <= 1'b0;
            seen_bad_ff <= 1'b0;
            minus_ff    <= 1'b0;
            value_ff    <= 64'd0;
            frac_ff     <= 6'd0;
            ovf_ff      <= 1'b0;
         end else if (pop) begin
            seen_dot_ff <= seen_dot_in;
            seen_bad_ff <= seen_bad_in;
            minus_ff    <= minus_in;
            value_ff    <= value_in;
            frac_ff     <= frac_in;
            ovf_ff      <= ovf_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `DSNP_ASSERT_NEXT(a_clear_after_last, load,
      value_ff == 64'd0 && !seen_bad_ff && frac_ff == 6'd0,
      "string state not cleared after final character")
   `DSNP_ASSERT_NOW(a_invalid_is_zero, rsp_valid_ff && !rsp_ff.is_valid,
      rsp_ff.mantissa == 64'd0 && !rsp_ff.saturated && !rsp_ff.is_negative,
      "invalid result carries nonzero fields")

endmodule
